// ----- design/xmb_pkg.sv -----
// Shared types, protocol codes and the CRC-16 byte update for the XMODEM block receiver.
`default_nettype none
package xmb_pkg;

  // Block geometry
  localparam int BLOCK_BYTES = 128;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int LEN_W       = $clog2(BLOCK_BYTES + 1);

  // Protocol bytes
  localparam logic [7:0] SOH_CODE      = 8'h01;
  localparam logic [7:0] EOT_CODE      = 8'h04;
  localparam logic [7:0] ACK_CODE      = 8'h06;
  localparam logic [7:0] NAK_CODE      = 8'h15;
  localparam logic [7:0] CRC_INIT_CODE = 8'h43;
  localparam logic [7:0] SUB_CODE      = 8'd26;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  // Request kinds on the input stream
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Block verdict codes
  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [1:0] VERDICT_REJECT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_NUM1,
    PH_NUM2,
    PH_DATA,
    PH_CHK1,
    PH_CHK2,
    PH_DONE
  } phase_t;

  // One result of the receiver
  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             wr_valid;
    logic [POS_W-1:0] wr_index;
    logic [7:0]       wr_data;
    logic [1:0]       verdict;
    logic             done_res;
    logic [7:0]       final_length;
  } result_t;

  // CRC-16 (poly 0x1021, MSB first) update by one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/xmb_step.sv -----
// Receiver state machine: block framing, check accumulation and result generation.
`default_nettype none
module xmb_step (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 fire,
  input  wire logic                 cmd,
  input  wire logic [7:0]           rx_byte,
  output xmb_pkg::result_t          res
);

  localparam logic [xmb_pkg::POS_W-1:0] LAST_POS = xmb_pkg::POS_W'(xmb_pkg::BLOCK_BYTES - 1);

  logic                         crc_mode;
  logic                         block_crc, block_crc_next;
  xmb_pkg::phase_t              phase, phase_next;
  logic [xmb_pkg::POS_W-1:0]    byte_position, byte_position_next;
  logic [15:0]                  running_check, running_check_next;
  logic [7:0]                   received_hi, received_hi_next;
  logic [xmb_pkg::LEN_W-1:0]    last_nonpad_count, last_nonpad_count_next;
  logic [xmb_pkg::LEN_W-1:0]    last_block_length, last_block_length_next;
  logic                         check_ok;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      crc_mode <= cfg_wr_data;
    end
  end

  // State registers, advanced once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= xmb_pkg::PH_IDLE;
      block_crc         <= 1'b1;
      byte_position     <= '0;
      running_check     <= '0;
      received_hi       <= '0;
      last_nonpad_count <= '0;
      last_block_length <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      block_crc         <= block_crc_next;
      byte_position     <= byte_position_next;
      running_check     <= running_check_next;
      received_hi       <= received_hi_next;
      last_nonpad_count <= last_nonpad_count_next;
      last_block_length <= last_block_length_next;
    end
  end

  // Next state and result
  always_comb begin
    phase_next             = phase;
    block_crc_next         = block_crc;
    byte_position_next     = byte_position;
    running_check_next     = running_check;
    received_hi_next       = received_hi;
    last_nonpad_count_next = last_nonpad_count;
    last_block_length_next = last_block_length;
    check_ok               = 1'b0;
    res                    = '0;

    if (cmd == xmb_pkg::CMD_START) begin
      res.tx_valid           = 1'b1;
      res.tx_byte            = crc_mode ? xmb_pkg::CRC_INIT_CODE : xmb_pkg::NAK_CODE;
      phase_next             = xmb_pkg::PH_WAIT;
      byte_position_next     = '0;
      running_check_next     = '0;
      received_hi_next       = '0;
      last_nonpad_count_next = '0;
      last_block_length_next = '0;
    end else begin
      unique case (phase)
        xmb_pkg::PH_WAIT: begin
          if (rx_byte == xmb_pkg::SOH_CODE) begin
            block_crc_next         = crc_mode;
            byte_position_next     = '0;
            running_check_next     = '0;
            received_hi_next       = '0;
            last_nonpad_count_next = '0;
            phase_next             = xmb_pkg::PH_NUM1;
          end else if (rx_byte == xmb_pkg::EOT_CODE) begin
            res.tx_valid     = 1'b1;
            res.tx_byte      = xmb_pkg::ACK_CODE;
            res.done_res     = 1'b1;
            res.final_length = 8'(last_block_length);
            phase_next       = xmb_pkg::PH_DONE;
          end
        end
        xmb_pkg::PH_NUM1: phase_next = xmb_pkg::PH_NUM2;
        xmb_pkg::PH_NUM2: phase_next = xmb_pkg::PH_DATA;
        xmb_pkg::PH_DATA: begin
          res.wr_valid = 1'b1;
          res.wr_index = byte_position;
          res.wr_data  = rx_byte;
          if (rx_byte != xmb_pkg::SUB_CODE) begin
            last_nonpad_count_next = xmb_pkg::LEN_W'(byte_position) + xmb_pkg::LEN_W'(1);
          end
          if (block_crc) begin
            running_check_next = xmb_pkg::crc_byte(running_check, rx_byte);
          end else begin
            running_check_next = {8'h00, running_check[7:0] + rx_byte};
          end
          if (byte_position == LAST_POS) begin
            byte_position_next = '0;
            phase_next         = xmb_pkg::PH_CHK1;
          end else begin
            byte_position_next = byte_position + 1'b1;
          end
        end
        xmb_pkg::PH_CHK1: begin
          if (block_crc) begin
            received_hi_next = rx_byte;
            phase_next       = xmb_pkg::PH_CHK2;
          end else begin
            check_ok    = (rx_byte == running_check[7:0]);
            res.tx_valid = 1'b1;
            res.tx_byte  = check_ok ? xmb_pkg::ACK_CODE : xmb_pkg::NAK_CODE;
            res.verdict  = check_ok ? xmb_pkg::VERDICT_ACCEPT : xmb_pkg::VERDICT_REJECT;
            if (check_ok) begin
              last_block_length_next = last_nonpad_count;
            end
            phase_next = xmb_pkg::PH_WAIT;
          end
        end
        xmb_pkg::PH_CHK2: begin
          check_ok     = ({received_hi, rx_byte} == running_check);
          res.tx_valid = 1'b1;
          res.tx_byte  = check_ok ? xmb_pkg::ACK_CODE : xmb_pkg::NAK_CODE;
          res.verdict  = check_ok ? xmb_pkg::VERDICT_ACCEPT : xmb_pkg::VERDICT_REJECT;
          if (check_ok) begin
            last_block_length_next = last_nonpad_count;
          end
          phase_next = xmb_pkg::PH_WAIT;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/xmodem_block_receiver.sv -----
// XMODEM block receiver top level: input register, receiver core and result register.
//
// Receive side of XMODEM with 128-byte blocks and CRC-16 or 8-bit checksum.
// Each request on s_axis (a start command or one received byte) yields exactly
// one result on m_axis: an optional response byte, an optional buffer write,
// the block verdict, and on EOT the trimmed length of the last accepted block.
// A request is taken every cycle while m_axis is not stalled. The input register
// holds the accepted request, and the result register is loaded from the
// combinational state update (CRC byte update included). crc_mode is written
// through cfg_wr_en/cfg_wr_data and should only change while no request is in
// flight; it is sampled at each block start and for the initiation byte.
`default_nettype none
module xmodem_block_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,     // crc_mode
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
  input  wire logic        s_axis_tuser,    // [0] command
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata     // [0] tx_valid, [8:1] tx_byte, [9] wr_valid,
                                            // [16:10] wr_index, [24:17] wr_data,
                                            // [26:25] verdict, [27] done_res,
                                            // [35:28] final_length, [39:36] zero
);

  logic              in_valid;
  logic              in_cmd;
  logic [7:0]        in_byte;
  logic              advance;
  xmb_pkg::result_t  res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  // Receiver core
  xmb_step u_step (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (advance),
    .cmd         (in_cmd),
    .rx_byte     (in_byte),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {4'h0, res.final_length, res.done_res, res.verdict, res.wr_data,
                       res.wr_index, res.wr_valid, res.tx_byte, res.tx_valid};
    end
  end

endmodule
`default_nettype wire

// ----- verif/xmb_result_checker.sv -----
// Result checker for the XMODEM block receiver: predicts each response and compares it.
module xmb_result_checker
  import xmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the receiver state
  phase_t           rx_phase;
  logic [POS_W-1:0] pos;
  logic [15:0]      run_chk;
  logic [15:0]      got_chk;
  logic [LEN_W-1:0] nonpad;
  logic [LEN_W-1:0] blk_len;
  logic             blk_crc;
  logic             crc_on;

  // Predicted responses, oldest first
  result_t due_results[$];

  // CRC-16/XMODEM, one input bit at a time
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Apply one request to the shadow state and return the response it causes
  function automatic result_t advance_receiver(input logic cmd, input logic [7:0] b);
    result_t r;
    logic    closing;
    logic    ok;
    r       = '0;
    closing = 1'b0;
    ok      = 1'b0;
    if (cmd == CMD_START) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = crc_on ? CRC_INIT_CODE : NAK_CODE;
      rx_phase   = PH_WAIT;
      pos        = '0;
      run_chk    = '0;
      got_chk    = '0;
      nonpad     = '0;
      blk_len    = '0;
    end else begin
      case (rx_phase)
        PH_WAIT: begin
          if (b == SOH_CODE) begin
            blk_crc  = crc_on;
            pos      = '0;
            run_chk  = '0;
            got_chk  = '0;
            nonpad   = '0;
            rx_phase = PH_NUM1;
          end else if (b == EOT_CODE) begin
            r.tx_valid     = 1'b1;
            r.tx_byte      = ACK_CODE;
            r.done_res     = 1'b1;
            r.final_length = 8'(blk_len);
            rx_phase       = PH_DONE;
          end
        end
        PH_NUM1: rx_phase = PH_NUM2;
        PH_NUM2: rx_phase = PH_DATA;
        PH_DATA: begin
          r.wr_valid = 1'b1;
          r.wr_index = pos;
          r.wr_data  = b;
          if (b != SUB_CODE) begin
            nonpad = LEN_W'(pos) + LEN_W'(1);
          end
          run_chk = blk_crc ? crc16_next(run_chk, b) : {8'h00, run_chk[7:0] + b};
          if (pos == POS_W'(BLOCK_BYTES - 1)) begin
            pos      = '0;
            rx_phase = PH_CHK1;
          end else begin
            pos = pos + 1'b1;
          end
        end
        PH_CHK1: begin
          if (blk_crc) begin
            got_chk  = {b, 8'h00};
            rx_phase = PH_CHK2;
          end else begin
            got_chk = {8'h00, b};
            closing = 1'b1;
            ok      = (b == run_chk[7:0]);
          end
        end
        PH_CHK2: begin
          got_chk[7:0] = b;
          closing      = 1'b1;
          ok           = (got_chk == run_chk);
        end
        default: ;
      endcase
    end
    // end of block: ACK or NAK, remember the trimmed length of a good block
    if (closing) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = ok ? ACK_CODE : NAK_CODE;
      r.verdict  = ok ? VERDICT_ACCEPT : VERDICT_REJECT;
      if (ok) begin
        blk_len = nonpad;
      end
      rx_phase = PH_WAIT;
    end
    return r;
  endfunction

  function automatic int field_miss(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Track both channels at each clock edge
  always @(posedge clk) begin
    result_t want;
    result_t got;
    int      bad;
    bad = 0;
    if (rst) begin
      rx_phase = PH_IDLE;
      pos      = '0;
      run_chk  = '0;
      got_chk  = '0;
      nonpad   = '0;
      blk_len  = '0;
      blk_crc  = 1'b1;
      crc_on   = 1'b1;
      due_results.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        crc_on = cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        due_results.push_back(advance_receiver(s_tuser, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got.tx_valid     = m_tdata[0];
        got.tx_byte      = m_tdata[8:1];
        got.wr_valid     = m_tdata[9];
        got.wr_index     = m_tdata[16:10];
        got.wr_data      = m_tdata[24:17];
        got.verdict      = m_tdata[26:25];
        got.done_res     = m_tdata[27];
        got.final_length = m_tdata[35:28];
        if (due_results.size() == 0) begin
          $display("%0t: response with none expected, expected nothing, got 0x%0h",
                   $time, m_tdata);
          bad++;
        end else begin
          want = due_results.pop_front();
          bad += field_miss("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
          bad += field_miss("tx_byte", want.tx_byte, got.tx_byte);
          bad += field_miss("wr_valid", 8'(want.wr_valid), 8'(got.wr_valid));
          bad += field_miss("wr_index", 8'(want.wr_index), 8'(got.wr_index));
          bad += field_miss("wr_data", want.wr_data, got.wr_data);
          bad += field_miss("verdict", 8'(want.verdict), 8'(got.verdict));
          bad += field_miss("done_res", 8'(want.done_res), 8'(got.done_res));
          bad += field_miss("final_length", want.final_length, got.final_length);
        end
      end
      errors  <= errors + bad;
      pending <= due_results.size();
    end
  end

endmodule

// ----- verif/tb_xmodem_block_receiver.sv -----
// Testbench top for the XMODEM block receiver: clock, reset, request stimulus and verdict.
module tb_xmodem_block_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import xmb_pkg::*;

  // Watchdog limit, far beyond the longest legal quiet stretch
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_REQS  = 650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = CMD_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int errors;
  int pending;

  // Stimulus bookkeeping
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  logic cur_crc = 1'b1;
  logic [7:0] blk_num = 8'd1;
  int   sent_reqs, n_good, n_bad, n_cut, n_eot, mode_writes, mid_flips;
  int   quiet;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  xmodem_block_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  xmb_result_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .errors      (errors),
    .pending     (pending)
  );

  // One request on s_axis, after an optional random gap
  task automatic push_req(input logic cmd, input logic [7:0] b, input bit counted);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (counted) begin
      sent_reqs++;
    end
  endtask

  // Hold the sender until every predicted response has come back
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the check mode register with nothing in flight
  task automatic set_mode(input logic crc_sel);
    settle_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= crc_sel;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_crc = crc_sel;
    mode_writes++;
  endtask

  // Full block: fault 0 clean, 1 bad check byte, 2 corrupted data byte
  task automatic send_block(input int fault, input int style);
    logic [7:0]  payload [BLOCK_BYTES];
    logic [7:0]  d;
    logic [7:0]  sum;
    logic [15:0] crc;
    logic [7:0]  chk_hi;
    logic [7:0]  chk_lo;
    logic        blk_mode;
    int          tail;
    int          bad_at;
    int          flip_at;
    sum  = 8'h00;
    crc  = 16'h0000;
    tail = $urandom_range(1, BLOCK_BYTES - 1);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      case (style)
        0: d = 8'($urandom);
        1: d = (i >= BLOCK_BYTES - tail) ? SUB_CODE : 8'($urandom);
        2: d = SUB_CODE;
        default: d = ($urandom_range(0, 2) == 0) ? SUB_CODE : 8'($urandom);
      endcase
      payload[i] = d;
      sum = sum + d;
      crc = crc ^ {d, 8'h00};
      for (int k = 0; k < 8; k++) begin
        crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
      end
    end
    blk_mode = cur_crc;
    bad_at   = $urandom_range(0, BLOCK_BYTES - 1);
    flip_at  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, BLOCK_BYTES - 1) : -1;
    // header: start byte, then block number and its complement, or two random bytes
    push_req(CMD_BYTE, SOH_CODE, 1'b1);
    if ($urandom_range(0, 7) == 0) begin
      push_req(CMD_BYTE, 8'($urandom), 1'b1);
      push_req(CMD_BYTE, 8'($urandom), 1'b1);
    end else begin
      push_req(CMD_BYTE, blk_num, 1'b1);
      push_req(CMD_BYTE, ~blk_num, 1'b1);
    end
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      d = payload[i];
      if (fault == 2 && i == bad_at) begin
        d = d ^ 8'($urandom_range(1, 255));
      end
      push_req(CMD_BYTE, d, 1'b1);
      // the block keeps the mode it started with
      if (i == flip_at) begin
        set_mode(~cur_crc);
        mid_flips++;
      end
    end
    chk_hi = blk_mode ? crc[15:8] : sum;
    chk_lo = crc[7:0];
    if (fault == 1) begin
      if (blk_mode && $urandom_range(0, 1) == 1) begin
        chk_lo = chk_lo ^ 8'($urandom_range(1, 255));
      end else begin
        chk_hi = chk_hi ^ 8'($urandom_range(1, 255));
      end
    end
    push_req(CMD_BYTE, chk_hi, 1'b1);
    if (blk_mode) begin
      push_req(CMD_BYTE, chk_lo, 1'b1);
    end
    blk_num = blk_num + 1'b1;
  endtask

  // Response sink with random stalls
  initial begin
    int stall;
    forever begin
      stall = rx_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
               $time, quiet, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main stimulus
  initial begin
    logic [7:0] junk;
    int         pick;
    int         phase_no;
    int         next_switch;
    int         cut;
    phase_no = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes before any start are dropped
    push_req(CMD_BYTE, SOH_CODE, 1'b1);
    push_req(CMD_BYTE, 8'hFF, 1'b1);
    push_req(CMD_BYTE, EOT_CODE, 1'b1);
    // start in CRC mode, then end of transfer with no block accepted
    push_req(CMD_START, 8'h00, 1'b1);
    push_req(CMD_BYTE, EOT_CODE, 1'b1);
    // dropped after the transfer ended
    push_req(CMD_BYTE, SOH_CODE, 1'b1);
    push_req(CMD_BYTE, 8'h00, 1'b1);
    // checksum mode start, junk while waiting for a block
    set_mode(1'b0);
    push_req(CMD_START, 8'hFF, 1'b1);
    push_req(CMD_BYTE, 8'h00, 1'b1);
    push_req(CMD_BYTE, 8'hFF, 1'b1);
    push_req(CMD_BYTE, ACK_CODE, 1'b1);
    // partial block, mode change mid-block, then a start abandons it
    push_req(CMD_BYTE, SOH_CODE, 1'b1);
    push_req(CMD_BYTE, 8'h01, 1'b1);
    push_req(CMD_BYTE, 8'hFE, 1'b1);
    push_req(CMD_BYTE, 8'h00, 1'b1);
    set_mode(1'b1);
    push_req(CMD_BYTE, 8'hFF, 1'b1);
    push_req(CMD_START, 8'h5A, 1'b1);
    push_req(CMD_BYTE, EOT_CODE, 1'b1);

    // opening of the random part: all-SUB block in checksum mode, then EOT
    set_mode(1'b0);
    push_req(CMD_START, 8'($urandom), 1'b1);
    send_block(0, 2);
    n_good++;
    push_req(CMD_BYTE, EOT_CODE, 1'b1);
    n_eot++;
    push_req(CMD_START, 8'($urandom), 1'b1);

    next_switch = sent_reqs + 130;
    while (sent_reqs < RAND_REQS) begin
      // new phase: other idling pattern and check mode
      if (sent_reqs >= next_switch) begin
        next_switch = sent_reqs + 130;
        phase_no++;
        tx_idle = (phase_no % 4 == 0) || (phase_no % 4 == 2);
        rx_idle = (phase_no % 4 == 0) || (phase_no % 4 == 3);
        set_mode(phase_no % 2 == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_block(0, $urandom_range(0, 3));
        n_good++;
      end else if (pick < 70) begin
        send_block($urandom_range(1, 2), $urandom_range(0, 3));
        n_bad++;
        if ($urandom_range(0, 2) == 0) begin
          settle_results();
        end
      end else if (pick < 78) begin
        // block cut short, recovered by a restart
        cut = $urandom_range(0, 20);
        push_req(CMD_BYTE, SOH_CODE, 1'b1);
        repeat (cut) push_req(CMD_BYTE, 8'($urandom), 1'b1);
        push_req(CMD_START, 8'($urandom), 1'b1);
        n_cut++;
      end else if (pick < 86) begin
        // line noise between blocks
        repeat ($urandom_range(1, 6)) begin
          junk = 8'($urandom);
          if (junk == SOH_CODE || junk == EOT_CODE) begin
            junk = ~junk;
          end
          push_req(CMD_BYTE, junk, 1'b0);
        end
      end else if (pick < 94) begin
        push_req(CMD_BYTE, EOT_CODE, 1'b1);
        repeat ($urandom_range(0, 3)) push_req(CMD_BYTE, 8'($urandom), 1'b0);
        push_req(CMD_START, 8'($urandom), 1'b1);
        n_eot++;
      end else begin
        push_req(CMD_START, 8'($urandom), 1'b1);
      end
    end

    settle_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d clean blocks, %0d corrupted, %0d cut short, %0d EOTs",
             sent_reqs, n_good, n_bad, n_cut, n_eot);
    $display("Check mode written %0d times, %0d of them inside a block",
             mode_writes, mid_flips);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
